// File: hw/rtl/line_point_generator_defines.svh
// Assertion macros shared by the line point generator checker.
`ifndef LINE_POINT_GENERATOR_DEFINES_SVH
`define LINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line point generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line point generator check failed");

`endif

// File: hw/rtl/lpg_pkg.sv
// Shared widths, defaults and types of the line point generator.
package lpg_pkg;

  localparam int unsigned CoordW    = 6;
  localparam int unsigned DeltaW    = CoordW + 1;
  localparam int unsigned TwiceW    = CoordW + 1;
  localparam int unsigned ErrW      = CoordW + 2;
  localparam int unsigned MaxPoints = 64;

  // Per-line constants that drive the error accumulator.
  typedef struct packed {
    logic [TwiceW-1:0] two_minor;
    logic [TwiceW-1:0] two_major;
  } step_cfg_t;

  // Result of one accumulator step.
  typedef struct packed {
    logic [ErrW-1:0] err;
    logic            carry;
  } step_res_t;

endpackage

// File: hw/rtl/lpg_step_unit.sv
// Add and compare-subtract unit that advances the minor-axis error term.
module lpg_step_unit (
  input  logic [lpg_pkg::ErrW-1:0] err_i,
  input  lpg_pkg::step_cfg_t       cfg_i,
  output lpg_pkg::step_res_t       res_o
);

  logic [lpg_pkg::ErrW-1:0] sum;
  logic [lpg_pkg::ErrW-1:0] limit;

  // The error stays below twice the major length, and the minor step never
  // exceeds it, so one conditional subtract keeps it in range.
  assign sum   = err_i + {1'b0, cfg_i.two_minor};
  assign limit = {1'b0, cfg_i.two_major};

  always_comb begin
    res_o.carry = (sum >= limit);
    res_o.err   = res_o.carry ? (sum - limit) : sum;
  end

endmodule

// File: hw/rtl/line_point_generator.sv
// Line point generator: emits every point of a line, origin first.
// Usage: an origin and a destination point are offered on the input channel
// (in_valid_i with in_stall_o). The block takes one line at a time; in_stall_o
// is high from the transfer of a line until its final point has been taken.
// Points leave on the output channel (out_valid_o with out_stall_i), one
// per cycle while the receiver does not stall, the final one flagged by
// last_point_o. The first point is shown in the cycle after the input transfer.
// A line whose longer axis spans N steps yields min(N+1, MAX_POINTS) points;
// the next line can be taken in the cycle after the final point's transfer.
// For each point the step unit advances the minor-axis error term by one add
// and one compare-subtract, which allows one point per cycle while the
// receiver does not stall. When the receiver stalls, the current point is
// held unchanged and the sequencer waits. Reset returns the block to idle
// with no point pending; a line in progress is dropped.
module line_point_generator #(
  parameter int unsigned MAX_POINTS = lpg_pkg::MaxPoints
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lpg_pkg::CoordW-1:0] origin_x_i,
  input  logic [lpg_pkg::CoordW-1:0] origin_y_i,
  input  logic [lpg_pkg::CoordW-1:0] dest_x_i,
  input  logic [lpg_pkg::CoordW-1:0] dest_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lpg_pkg::CoordW-1:0] point_x_o,
  output logic [lpg_pkg::CoordW-1:0] point_y_o,
  output logic                       last_point_o
);

  localparam int unsigned CntW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam logic [lpg_pkg::CoordW:0] LimM = (lpg_pkg::CoordW + 1)'(MAX_POINTS - 1);

  typedef enum logic {
    IDLE,
    RUN
  } state_e;

  state_e                     state_q;
  logic [lpg_pkg::CoordW-1:0] px_q, py_q;
  logic [lpg_pkg::ErrW-1:0]   err_q;
  logic [CntW-1:0]            rem_q;
  logic                       neg_x_q, neg_y_q, x_major_q;
  lpg_pkg::step_cfg_t         cfg_q;

  // Line setup.
  logic signed [lpg_pkg::DeltaW-1:0] dx, dy, ax_full, ay_full;
  logic [lpg_pkg::CoordW-1:0]        ax, ay, major, minor;
  logic                              x_major;
  logic [CntW-1:0]                   rem_init;

  always_comb begin
    dx      = $signed({dest_x_i[lpg_pkg::CoordW-1], dest_x_i})
            - $signed({origin_x_i[lpg_pkg::CoordW-1], origin_x_i});
    dy      = $signed({dest_y_i[lpg_pkg::CoordW-1], dest_y_i})
            - $signed({origin_y_i[lpg_pkg::CoordW-1], origin_y_i});
    ax_full = dx[lpg_pkg::DeltaW-1] ? -dx : dx;
    ay_full = dy[lpg_pkg::DeltaW-1] ? -dy : dy;
    ax      = ax_full[lpg_pkg::CoordW-1:0];
    ay      = ay_full[lpg_pkg::CoordW-1:0];
    x_major = (ax >= ay);
    major   = x_major ? ax : ay;
    minor   = x_major ? ay : ax;
    if ({1'b0, major} > LimM) begin
      rem_init = LimM[CntW-1:0];
    end else begin
      rem_init = major[CntW-1:0];
    end
  end

  lpg_pkg::step_res_t step_res;

  lpg_step_unit u_step (
    .err_i (err_q),
    .cfg_i (cfg_q),
    .res_o (step_res)
  );

  logic                       in_xfer, out_xfer, is_last;
  logic                       move_x, move_y;
  logic [lpg_pkg::CoordW-1:0] px_d, py_d;

  assign in_xfer  = in_valid_i && (state_q == IDLE);
  assign is_last  = (rem_q == '0);
  assign out_xfer = (state_q == RUN) && !out_stall_i;

  always_comb begin
    move_x = x_major_q || step_res.carry;
    move_y = !x_major_q || step_res.carry;
    px_d   = px_q;
    py_d   = py_q;
    if (move_x) begin
      px_d = neg_x_q ? (px_q - 1'b1) : (px_q + 1'b1);
    end
    if (move_y) begin
      py_d = neg_y_q ? (py_q - 1'b1) : (py_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      px_q      <= '0;
      py_q      <= '0;
      err_q     <= '0;
      rem_q     <= '0;
      neg_x_q   <= 1'b0;
      neg_y_q   <= 1'b0;
      x_major_q <= 1'b0;
      cfg_q     <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (in_xfer) begin
            state_q         <= RUN;
            px_q            <= origin_x_i;
            py_q            <= origin_y_i;
            err_q           <= {2'b00, major};
            rem_q           <= rem_init;
            neg_x_q         <= dx[lpg_pkg::DeltaW-1];
            neg_y_q         <= dy[lpg_pkg::DeltaW-1];
            x_major_q       <= x_major;
            cfg_q.two_major <= {major, 1'b0};
            cfg_q.two_minor <= {minor, 1'b0};
          end
        end
        RUN: begin
          if (out_xfer) begin
            if (is_last) begin
              state_q <= IDLE;
            end else begin
              px_q  <= px_d;
              py_q  <= py_d;
              err_q <= step_res.err;
              rem_q <= rem_q - 1'b1;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != IDLE);
  assign out_valid_o  = (state_q == RUN);
  assign point_x_o    = px_q;
  assign point_y_o    = py_q;
  assign last_point_o = is_last;

endmodule

// File: hw/rtl/lpg_checker.sv
// Port-level checker for the line point generator, bound to the top level.
`include "line_point_generator_defines.svh"

module lpg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [lpg_pkg::CoordW-1:0] point_x_o,
  input logic [lpg_pkg::CoordW-1:0] point_y_o,
  input logic                       last_point_o
);

  // A new line is never taken while points of the current one are pending.
  `LPG_ASSERT_IMPL(a_busy_stalls_input, clk_i, rst_ni, out_valid_o, in_stall_o)

  // A point is shown in the cycle after the input transfer.
  `LPG_ASSERT_NEXT(a_first_point, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)

  // Points follow without a gap until the flagged final one.
  `LPG_ASSERT_NEXT(a_no_gap, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && !last_point_o, out_valid_o)

  // The final transfer ends the line.
  `LPG_ASSERT_NEXT(a_line_ends, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && last_point_o, !out_valid_o)

  // A stalled point is held.
  `LPG_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(point_x_o) && $stable(point_y_o))

endmodule

bind line_point_generator lpg_checker u_lpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .point_x_o    (point_x_o),
  .point_y_o    (point_y_o),
  .last_point_o (last_point_o)
);

// File: bench/line_point_generator_checker.sv
// Checker for the line point generator: predicts every line point and compares each transfer.
module line_point_generator_checker #(
  parameter int unsigned MaxPoints = lpg_pkg::MaxPoints
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [lpg_pkg::CoordW-1:0] origin_x_i,
  input  logic [lpg_pkg::CoordW-1:0] origin_y_i,
  input  logic [lpg_pkg::CoordW-1:0] dest_x_i,
  input  logic [lpg_pkg::CoordW-1:0] dest_y_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [lpg_pkg::CoordW-1:0] point_x_i,
  input  logic [lpg_pkg::CoordW-1:0] point_y_i,
  input  logic                       last_point_i,
  output int unsigned                pending_o,
  output int unsigned                error_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lpg_pkg::CoordW-1:0] x;
    logic [lpg_pkg::CoordW-1:0] y;
    logic                       last;
  } line_point_t;

  line_point_t line_points_due[$];
  line_point_t next_point;

  initial begin
    pending_o     = 0;
    error_count_o = 0;
  end

  // Walks the major axis one step per point; the minor offset is rounded half up.
  function automatic void rasterize(input logic signed [lpg_pkg::CoordW-1:0] ox,
                                    input logic signed [lpg_pkg::CoordW-1:0] oy,
                                    input logic signed [lpg_pkg::CoordW-1:0] tx,
                                    input logic signed [lpg_pkg::CoordW-1:0] ty);
    int          dx, dy, ax, ay, major, minor, count, moff, offx, offy, px, py;
    bit          neg_x, neg_y, x_major;
    line_point_t p;
    dx      = int'(tx) - int'(ox);
    dy      = int'(ty) - int'(oy);
    neg_x   = dx < 0;
    neg_y   = dy < 0;
    ax      = neg_x ? -dx : dx;
    ay      = neg_y ? -dy : dy;
    x_major = ax >= ay;
    major   = x_major ? ax : ay;
    minor   = x_major ? ay : ax;
    count   = major + 1;
    if (count > int'(MaxPoints)) begin
      count = int'(MaxPoints);
    end
    for (int i = 0; i < count; i++) begin
      moff = 0;
      if (minor != 0) begin
        moff = (2 * i * minor + major) / (2 * major);
      end
      offx   = x_major ? i : moff;
      offy   = x_major ? moff : i;
      px     = neg_x ? int'(ox) - offx : int'(ox) + offx;
      py     = neg_y ? int'(oy) - offy : int'(oy) + offy;
      p.x    = px[lpg_pkg::CoordW-1:0];
      p.y    = py[lpg_pkg::CoordW-1:0];
      p.last = (i == count - 1);
      line_points_due.push_back(p);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        rasterize($signed(origin_x_i), $signed(origin_y_i), $signed(dest_x_i),
                  $signed(dest_y_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (line_points_due.size() == 0) begin
          $error("point transfer (%0d, %0d) with no point expected",
                 $signed(point_x_i), $signed(point_y_i));
          error_count_o++;
        end else begin
          next_point = line_points_due.pop_front();
          if (point_x_i !== next_point.x) begin
            $error("point_x: expected %0d, actual %0d", $signed(next_point.x),
                   $signed(point_x_i));
            error_count_o++;
          end
          if (point_y_i !== next_point.y) begin
            $error("point_y: expected %0d, actual %0d", $signed(next_point.y),
                   $signed(point_y_i));
            error_count_o++;
          end
          if (last_point_i !== next_point.last) begin
            $error("last_point: expected %0b, actual %0b", next_point.last, last_point_i);
            error_count_o++;
          end
        end
      end
      pending_o = line_points_due.size();
    end
  end

endmodule

// File: bench/line_point_generator_tb.sv
// Testbench top for the line point generator: clock, reset, line stimulus and verdict.
module line_point_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 2000;
  localparam int          NumRandomLines = 400;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [lpg_pkg::CoordW-1:0] origin_x_i;
  logic [lpg_pkg::CoordW-1:0] origin_y_i;
  logic [lpg_pkg::CoordW-1:0] dest_x_i;
  logic [lpg_pkg::CoordW-1:0] dest_y_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [lpg_pkg::CoordW-1:0] point_x_o;
  logic [lpg_pkg::CoordW-1:0] point_y_o;
  logic                       last_point_o;

  int unsigned points_pending;
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          steady;

  line_point_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .origin_x_i   (origin_x_i),
    .origin_y_i   (origin_y_i),
    .dest_x_i     (dest_x_i),
    .dest_y_i     (dest_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .last_point_o (last_point_o)
  );

  line_point_generator_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .dest_x_i      (dest_x_i),
    .dest_y_i      (dest_y_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .point_x_i     (point_x_o),
    .point_y_i     (point_y_o),
    .last_point_i  (last_point_o),
    .pending_o     (points_pending),
    .error_count_o (error_count)
  );

  always #4 clk_i = ~clk_i;

  // The receiver stalls now and then, except during the steady stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 13);
  end

  // Ends the run when no transfer has happened on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one line and returns right after the rising edge of its transfer.
  // Coordinates are taken modulo the field width.
  task automatic send_line(input int ox, input int oy, input int tx, input int ty);
    if (!steady && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    origin_x_i <= ox[lpg_pkg::CoordW-1:0];
    origin_y_i <= oy[lpg_pkg::CoordW-1:0];
    dest_x_i   <= tx[lpg_pkg::CoordW-1:0];
    dest_y_i   <= ty[lpg_pkg::CoordW-1:0];
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Holds the input back until every predicted point has been transferred.
  task automatic drain_points();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (points_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int ox, oy, tx, ty;
    int shape;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    origin_x_i  = '0;
    origin_y_i  = '0;
    dest_x_i    = '0;
    dest_y_i    = '0;
    idle_cycles = 0;
    steady      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero-length lines at both corners of the range.
    send_line(-32, -32, -32, -32);
    send_line(31, 31, 31, 31);
    // Full-range lines with no minor difference, in each direction.
    send_line(-32, 5, 31, 5);
    send_line(31, -7, -32, -7);
    send_line(3, -32, 3, 31);
    send_line(-9, 31, -9, -32);
    // Diagonals, where the tie makes x the major axis.
    send_line(-32, -32, 31, 31);
    send_line(31, -32, -32, 31);
    // Lines with minor offsets, some landing exactly on one half, which rounds up.
    send_line(0, 0, 2, 1);
    send_line(0, 0, -4, -2);
    send_line(0, 0, 1, 3);
    send_line(5, 5, 2, -10);
    send_line(-32, 31, 31, 0);
    send_line(10, -3, 11, -3);
    send_line(0, 0, 0, 1);
    send_line(-20, 7, 13, -31);
    drain_points();

    for (int k = 0; k < NumRandomLines; k++) begin
      steady = (k >= 150) && (k < 250);
      if (k == 100 || k == 300) begin
        drain_points();
      end
      ox    = int'($urandom_range(63));
      oy    = int'($urandom_range(63));
      tx    = int'($urandom_range(63));
      ty    = int'($urandom_range(63));
      shape = int'($urandom_range(9));
      case (shape)
        0: begin
          tx = ox;
          ty = oy;
        end
        1: begin
          ty = oy;
        end
        2: begin
          tx = ox;
        end
        default: begin
        end
      endcase
      send_line(ox, oy, tx, ty);
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    @(negedge clk_i);
    while (points_pending != 0) @(negedge clk_i);
    repeat (70) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
